// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/bcm_pkg.sv -----
`default_nettype none

package bcm_pkg;

  localparam int MaxWidth = 1024;
  localparam int ColW     = $clog2(MaxWidth);
  localparam int WidthW   = 11;
  localparam int HeightW  = 16;
  localparam int PendW    = $clog2(MaxWidth + 2);
  localparam int PixW     = 8;
  localparam int CfgDataW = 16;
  localparam int CfgIdxW  = 2;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;
  localparam cfg_idx_t CfgFrameWidth  = 2'd0;
  localparam cfg_idx_t CfgFrameHeight = 2'd1;

  localparam logic [WidthW-1:0]  WidthReset  = 11'd640;
  localparam logic [WidthW-1:0]  WidthMin    = 11'd3;
  localparam logic [WidthW-1:0]  WidthMax    = WidthW'(MaxWidth);
  localparam logic [HeightW-1:0] HeightReset = 16'd480;
  localparam logic [HeightW-1:0] HeightMin   = 16'd3;

  localparam logic [PixW-1:0] PixFull = 8'd255;
  localparam logic [PixW-1:0] PixMark = 8'd127;
  localparam logic [PixW-1:0] PixZero = 8'd0;

  // Result item as held in the output queue.
  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic            frame_last;
  } res_t;

  localparam int FifoDepth = 3;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

endpackage

`default_nettype wire

// ----- rtl/bcm_out_fifo.sv -----
`default_nettype none
`include "assert_macros.svh"

module bcm_out_fifo (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push_i,
  input  wire bcm_pkg::res_t                 push_data_i,
  input  wire logic                          pop_ready_i,
  output logic                               valid_o,
  output bcm_pkg::res_t                      data_o,
  output logic [bcm_pkg::FifoCntW-1:0]       count_o
);

  bcm_pkg::res_t                 store_q [bcm_pkg::FifoDepth];
  logic [bcm_pkg::FifoPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [bcm_pkg::FifoCntW-1:0]  cnt_q;
  logic                          full, pop, wr_en;

  assign full    = (cnt_q == bcm_pkg::FifoCntW'(bcm_pkg::FifoDepth));
  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && pop_ready_i;
  assign wr_en   = push_i && !full;
  assign data_o  = store_q[rd_ptr_q];
  assign count_o = cnt_q;

  function automatic logic [bcm_pkg::FifoPtrW-1:0] ptr_inc(
    input logic [bcm_pkg::FifoPtrW-1:0] p
  );
    if (p == bcm_pkg::FifoPtrW'(bcm_pkg::FifoDepth - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (wr_en && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !wr_en) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `ASSERT_IMPLIES(a_no_overflow, clk_i, rst_ni, push_i, !full, "result queue overflow")
  `ASSERT_NEXT(a_count_track, clk_i, rst_ni, 1'b1,
    cnt_q == $past(cnt_q) + $past(push_i) - $past(pop), "queue count out of step")
  `ASSERT_NEXT(a_rd_hold, clk_i, rst_ni, !pop, $stable(rd_ptr_q), "read pointer moved")

endmodule

`default_nettype wire

// ----- rtl/binary_contour_marker_3x3.sv -----
// A result request is offered after its completing pixel passes the window stage and the
// result queue. Throughput: one request per cycle on both sides unless stalled; the single
// line memory is read once and written once per cycle, and a three-entry result queue
// absorbs stalls. Reset: counters, window and queue cleared, frame size 640 x 480; line
// memory contents are left as they are (never-written entries only feed border results).
`default_nettype none
`include "assert_macros.svh"

module binary_contour_marker_3x3 (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [7:0]                     s_axis_tdata,   // [7:0] pixel_in
  input  wire logic                           s_axis_tuser,   // [0] drain
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [7:0]                          m_axis_tdata,   // [7:0] pixel_out
  output logic                                m_axis_tlast,
  input  wire logic                           cfg_we_i,
  input  wire logic [bcm_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [bcm_pkg::CfgDataW-1:0]   cfg_data_i
);

  localparam int PixW = bcm_pkg::PixW;

  // Configuration, stored already clamped
  logic [bcm_pkg::WidthW-1:0]  width_q, w_clamp, w_raw, width_last, width_p1;
  logic [bcm_pkg::HeightW-1:0] height_q, h_clamp, height_last;
  logic                        cfg_hit;

  // Position counters
  logic [bcm_pkg::ColW-1:0]    in_col_q, in_col_d, out_col_q, out_col_d, out_col_b;
  logic [bcm_pkg::HeightW-1:0] in_row_q, in_row_d, out_row_q, out_row_d, out_row_b;
  logic [bcm_pkg::PendW-1:0]   pend_q, pend_d;
  logic [bcm_pkg::WidthW-1:0]  in_col_w, out_col_w;

  logic s_accept, is_drain, at_start, pend_full, drain_emit, restart, pix_emit, emit;
  logic interior, frame_last;

  // Line memory: [7:0] older row, [15:8] newer row
  logic [2*PixW-1:0]        line_mem [bcm_pkg::MaxWidth];
  logic [2*PixW-1:0]        rd_data_q, byp_data_q, line_data, mem_wdata;
  logic                     byp_q, mem_we;
  logic [bcm_pkg::ColW-1:0] rd_addr;

  // Window stage
  logic                     s1_valid_q, s1_emit_q;
  logic                     s1_pix_q, s1_win_sel_q, s1_interior_q, s1_last_q;
  logic [bcm_pkg::ColW-1:0] s1_addr_q;
  logic [PixW-1:0]          s1_data_q;
  logic [PixW-1:0]          win_q [3][3];
  logic [PixW-1:0]          win_d [3][3];
  logic [PixW-1:0]          row0_rd, row1_rd, centre;
  logic                     nb_zero, contour;

  bcm_pkg::res_t                 res;
  bcm_pkg::res_t                 out_item;
  logic [bcm_pkg::FifoCntW-1:0]  fifo_cnt;
  logic [bcm_pkg::FifoCntW:0]    occupancy;

  // ---------------- configuration ----------------
  assign w_raw = cfg_data_i[bcm_pkg::WidthW-1:0];

  always_comb begin
    w_clamp = w_raw;
    if (w_raw < bcm_pkg::WidthMin) begin
      w_clamp = bcm_pkg::WidthMin;
    end else if (w_raw > bcm_pkg::WidthMax) begin
      w_clamp = bcm_pkg::WidthMax;
    end
    h_clamp = cfg_data_i;
    if (cfg_data_i < bcm_pkg::HeightMin) begin
      h_clamp = bcm_pkg::HeightMin;
    end
  end

  assign cfg_hit = cfg_we_i &&
                   (cfg_idx_i == bcm_pkg::CfgFrameWidth || cfg_idx_i == bcm_pkg::CfgFrameHeight);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bcm_pkg::WidthReset;
      height_q <= bcm_pkg::HeightReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bcm_pkg::CfgFrameWidth:  width_q  <= w_clamp;
        bcm_pkg::CfgFrameHeight: height_q <= h_clamp;
        default: ;
      endcase
    end
  end

  // ---------------- request decode ----------------
  assign width_last  = width_q - 1'b1;
  assign width_p1    = width_q + 1'b1;
  assign height_last = height_q - 1'b1;
  assign in_col_w    = {1'b0, in_col_q};
  assign out_col_w   = {1'b0, out_col_q};

  assign s_accept  = s_axis_tvalid && s_axis_tready;
  assign is_drain  = s_axis_tuser;
  assign at_start  = (in_col_q == '0) && (in_row_q == '0);
  assign pend_full = (pend_q == width_p1);

  // Flush only once the frame has wrapped; a pixel after a started flush
  // drops what is left and opens a fresh frame.
  assign drain_emit = at_start && (pend_q != '0) && (pend_q <= width_p1);
  assign restart    = at_start && (pend_q != '0) && (pend_q < width_p1);
  assign pix_emit   = !restart && pend_full;
  assign emit       = is_drain ? drain_emit : pix_emit;

  assign interior   = (out_row_q != '0) && (out_row_q < height_last) &&
                      (out_col_q != '0) && (out_col_w < width_last);
  assign frame_last = (out_col_w == width_last) && (out_row_q == height_last);

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    pend_d    = pend_q;
    out_col_b = out_col_q;
    out_row_b = out_row_q;
    if (s_accept && !is_drain && restart) begin
      out_col_b = '0;
      out_row_b = '0;
    end
    out_col_d = out_col_b;
    out_row_d = out_row_b;

    if (s_accept && emit) begin
      if (frame_last) begin
        out_col_d = '0;
        out_row_d = '0;
      end else if (out_col_w == width_last) begin
        out_col_d = '0;
        out_row_d = out_row_q + 1'b1;
      end else begin
        out_col_d = out_col_q + 1'b1;
      end
    end

    if (s_accept && !is_drain) begin
      if (in_col_w == width_last) begin
        in_col_d = '0;
        in_row_d = (in_row_q == height_last) ? '0 : in_row_q + 1'b1;
      end else begin
        in_col_d = in_col_q + 1'b1;
      end
      if (restart) begin
        pend_d = bcm_pkg::PendW'(1);
      end else if (!pix_emit) begin
        pend_d = pend_q + 1'b1;
      end
    end else if (s_accept && drain_emit) begin
      pend_d = pend_q - 1'b1;
    end

    if (cfg_hit) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
      pend_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      pend_q    <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      pend_q    <= pend_d;
    end
  end

  // ---------------- line memory ----------------
  assign rd_addr   = is_drain ? out_col_q : in_col_q;
  assign mem_we    = s1_valid_q && s1_pix_q;
  assign line_data = byp_q ? byp_data_q : rd_data_q;
  assign row0_rd   = line_data[PixW-1:0];
  assign row1_rd   = line_data[2*PixW-1:PixW];
  assign mem_wdata = {s1_data_q, row1_rd};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem[s1_addr_q] <= mem_wdata;
    end
    if (s_accept) begin
      rd_data_q <= line_mem[rd_addr];
    end
  end

  // write-to-read forwarding when the window stage writes the column being read
  always_ff @(posedge clk_i) begin
    byp_q      <= mem_we && (s1_addr_q == rd_addr);
    byp_data_q <= mem_wdata;
  end

  // ---------------- window stage ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_emit_q  <= 1'b0;
    end else begin
      s1_valid_q <= s_accept && (!is_drain || drain_emit);
      s1_emit_q  <= s_accept && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_pix_q      <= !is_drain;
    s1_win_sel_q  <= pend_full;
    s1_interior_q <= interior;
    s1_last_q     <= frame_last;
    s1_addr_q     <= in_col_q;
    s1_data_q     <= s_axis_tdata;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        win_d[i][j] = win_q[i][j];
      end
    end
    if (mem_we) begin
      for (int i = 0; i < 3; i++) begin
        win_d[i][0] = win_q[i][1];
        win_d[i][1] = win_q[i][2];
      end
      win_d[0][2] = row0_rd;
      win_d[1][2] = row1_rd;
      win_d[2][2] = s1_data_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= bcm_pkg::PixZero;
        end
      end
    end else begin
      win_q <= win_d;
    end
  end

  always_comb begin
    nb_zero = 1'b0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if ((i != 1 || j != 1) && win_d[i][j] == bcm_pkg::PixZero) begin
          nb_zero = 1'b1;
        end
      end
    end
  end

  assign centre  = win_d[1][1];
  assign contour = (centre == bcm_pkg::PixFull) && s1_interior_q && nb_zero;

  always_comb begin
    if (s1_pix_q) begin
      res.pixel = contour ? bcm_pkg::PixMark : centre;
    end else begin
      // flush: newest window column while it still holds the pending pixel,
      // otherwise the last row straight from the line memory
      res.pixel = s1_win_sel_q ? win_q[1][2] : row1_rd;
    end
    res.frame_last = s1_last_q;
  end

  // ---------------- result queue ----------------
  assign occupancy     = {1'b0, fifo_cnt} + {{bcm_pkg::FifoCntW{1'b0}}, s1_emit_q};
  assign s_axis_tready = (occupancy < (bcm_pkg::FifoCntW + 1)'(bcm_pkg::FifoDepth));

  bcm_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s1_valid_q && s1_emit_q),
    .push_data_i (res),
    .pop_ready_i (m_axis_tready),
    .valid_o     (m_axis_tvalid),
    .data_o      (out_item),
    .count_o     (fifo_cnt)
  );

  assign m_axis_tdata = out_item.pixel;
  assign m_axis_tlast = out_item.frame_last;

  `ASSERT_ALWAYS(a_pend_bound, clk_i, rst_ni, pend_q <= width_p1, "pending count too large")
  `ASSERT_ALWAYS(a_out_col_bound, clk_i, rst_ni, out_col_w < width_q, "output column overrun")
  `ASSERT_IMPLIES(a_emit_origin, clk_i, rst_ni, s1_emit_q, $past(s_accept),
    "result without an accepted request")

endmodule

`default_nettype wire
